@@ src/pvd_pkg.sv @@
// Shared types and register indexes for the peak/valley detector.
package pvd_pkg;

    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 15;
    localparam int PERSIST_BITS  = 8;
    localparam int MARGIN_BITS   = 15;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_PERSIST_COUNT  = 2'd0,
        CFG_MARGIN         = 2'd1,
        CFG_REPORT_TOPS    = 2'd2,
        CFG_REPORT_BOTTOMS = 2'd3
    } cfg_addr_t;

    typedef struct packed {
        logic [PERSIST_BITS-1:0] persist_count;
        logic [MARGIN_BITS-1:0]  margin;
        logic                    report_tops;
        logic                    report_bottoms;
    } cfg_t;

    typedef struct packed {
        logic peak_flag;
        logic turn_was_top;
    } flags_t;

endpackage

@@ src/pvd_cfg_regs.sv @@
// Configuration register file for the peak/valley detector.
module pvd_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [pvd_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [pvd_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    output pvd_pkg::cfg_t                       cfg
);
    import pvd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.persist_count  <= PERSIST_BITS'(1);
            cfg_reg.margin         <= '0;
            cfg_reg.report_tops    <= 1'b1;
            cfg_reg.report_bottoms <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr_t'(cfg_addr))
                CFG_PERSIST_COUNT:  cfg_reg.persist_count  <= cfg_wdata[PERSIST_BITS-1:0];
                CFG_MARGIN:         cfg_reg.margin         <= cfg_wdata[MARGIN_BITS-1:0];
                CFG_REPORT_TOPS:    cfg_reg.report_tops    <= cfg_wdata[0];
                CFG_REPORT_BOTTOMS: cfg_reg.report_bottoms <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/pvd_track.sv @@
// Trend tracker: extreme, persistence counter, direction and held peaks.
module pvd_track #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pvd_pkg::cfg_t                  cfg,
    input  logic                           fire,
    input  logic signed [SAMPLE_BITS-1:0]  sample,
    output pvd_pkg::flags_t                flags,
    output logic signed [SAMPLE_BITS-1:0]  last_top,
    output logic signed [SAMPLE_BITS-1:0]  last_bottom
);
    import pvd_pkg::*;

    // Wide enough that extreme plus or minus the margin cannot overflow.
    localparam int CMP_W = ((SAMPLE_BITS > MARGIN_BITS) ? SAMPLE_BITS : MARGIN_BITS + 1) + 1;

    logic                          rising_reg, rising_next;
    logic signed [SAMPLE_BITS-1:0] extreme_reg, extreme_next;
    logic [PERSIST_BITS-1:0]       count_reg, count_next;
    logic signed [SAMPLE_BITS-1:0] top_hold_reg, top_hold_next;
    logic signed [SAMPLE_BITS-1:0] bottom_hold_reg, bottom_hold_next;

    logic signed [CMP_W-1:0] sample_w;
    logic signed [CMP_W-1:0] extreme_w;
    logic signed [CMP_W-1:0] margin_w;
    logic signed [CMP_W-1:0] band_lo;
    logic signed [CMP_W-1:0] band_hi;
    logic [PERSIST_BITS:0]   count_inc;
    logic                    turn_ok;
    logic                    top_turn;
    logic                    flag;

    assign sample_w  = CMP_W'(sample);
    assign extreme_w = CMP_W'(extreme_reg);
    assign margin_w  = CMP_W'($signed({1'b0, cfg.margin}));
    assign band_lo   = extreme_w - margin_w;
    assign band_hi   = extreme_w + margin_w;
    assign count_inc = {1'b0, count_reg} + (PERSIST_BITS + 1)'(1);
    // A setting of zero behaves like one, since the incremented count is never zero.
    assign turn_ok   = (count_inc >= {1'b0, cfg.persist_count});

    always_comb begin
        rising_next      = rising_reg;
        extreme_next     = extreme_reg;
        count_next       = count_reg;
        top_hold_next    = top_hold_reg;
        bottom_hold_next = bottom_hold_reg;
        top_turn         = 1'b0;
        flag             = 1'b0;
        if (rising_reg) begin
            if (sample_w < band_lo) begin
                if (turn_ok) begin
                    count_next    = '0;
                    top_hold_next = extreme_reg;
                    extreme_next  = sample;
                    rising_next   = 1'b0;
                    top_turn      = 1'b1;
                    flag          = cfg.report_tops;
                end else begin
                    count_next = count_inc[PERSIST_BITS-1:0];
                end
            end else if (sample > extreme_reg) begin
                count_next   = '0;
                extreme_next = sample;
            end
        end else begin
            if (sample_w > band_hi) begin
                if (turn_ok) begin
                    count_next       = '0;
                    bottom_hold_next = extreme_reg;
                    extreme_next     = sample;
                    rising_next      = 1'b1;
                    flag             = cfg.report_bottoms;
                end else begin
                    count_next = count_inc[PERSIST_BITS-1:0];
                end
            end else if (sample < extreme_reg) begin
                count_next   = '0;
                extreme_next = sample;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rising_reg      <= 1'b1;
            extreme_reg     <= '0;
            count_reg       <= '0;
            top_hold_reg    <= '0;
            bottom_hold_reg <= '0;
        end else if (fire) begin
            rising_reg      <= rising_next;
            extreme_reg     <= extreme_next;
            count_reg       <= count_next;
            top_hold_reg    <= top_hold_next;
            bottom_hold_reg <= bottom_hold_next;
        end
    end

    assign flags.peak_flag    = flag;
    assign flags.turn_was_top = top_turn;
    assign last_top           = top_hold_next;
    assign last_bottom        = bottom_hold_next;

    a_top_turn_falls: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && top_turn) |=> !rising_reg)
        else $error("top turn did not switch direction to falling");

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> ($stable(extreme_reg) && $stable(rising_reg) && $stable(count_reg)))
        else $error("tracker state changed without an accepted word");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != {PERSIST_BITS{1'b1}})
        else $error("persistence counter reached its wrap value");

    a_flag_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && flag && !top_turn) |-> (!rising_reg && cfg.report_bottoms))
        else $error("flag raised without a confirmed, reported turn");

endmodule

@@ src/peak_valley_detector.sv @@
// Top level of the hysteresis peak/valley detector.
// A word accepted on s_ passes the input and then the result register on to m_.
// One word per cycle while m_ready is high; one compare-and-select state update.
// The input register and the result register each free themselves as they drain.
// Reset (aresetn low, synchronous) empties both stages, sets direction to rising,
// clears extreme, counter and held peaks, and loads the register defaults.
module peak_valley_detector #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [pvd_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [pvd_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SAMPLE_BITS-1:0]       s_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_peak_flag,
    output logic                                m_turn_was_top,
    output logic signed [SAMPLE_BITS-1:0]       m_last_top,
    output logic signed [SAMPLE_BITS-1:0]       m_last_bottom
);
    import pvd_pkg::*;

    cfg_t                          cfg;
    flags_t                        flags;
    logic signed [SAMPLE_BITS-1:0] last_top;
    logic signed [SAMPLE_BITS-1:0] last_bottom;

    logic                          in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;
    logic                          out_valid_reg;
    flags_t                        out_flags_reg;
    logic signed [SAMPLE_BITS-1:0] out_top_reg;
    logic signed [SAMPLE_BITS-1:0] out_bottom_reg;
    logic                          fire;

    // A word moves to the result register when that register is empty or draining.
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    pvd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pvd_track #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_track (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .fire        (fire),
        .sample      (in_sample_reg),
        .flags       (flags),
        .last_top    (last_top),
        .last_bottom (last_bottom)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg <= s_sample;
        end
        if (fire) begin
            out_flags_reg  <= flags;
            out_top_reg    <= last_top;
            out_bottom_reg <= last_bottom;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_peak_flag    = out_flags_reg.peak_flag;
    assign m_turn_was_top = out_flags_reg.turn_was_top;
    assign m_last_top     = out_top_reg;
    assign m_last_bottom  = out_bottom_reg;

    a_fire_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid)
        else $error("processed word did not reach the result register");

    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled while the pipeline could move");

    a_accept_fills_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_valid_reg)
        else $error("accepted word was lost from the input register");

endmodule

@@ verif/tb_peak_valley_detector.sv @@
// Self-checking testbench for the peak/valley detector: directed and random sample streams.
module tb_peak_valley_detector;
    timeunit 1ns;
    timeprecision 1ps;

    import pvd_pkg::*;

    localparam int SAMPLE_BITS     = 16;
    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 9;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 244;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 6;
    localparam int CYCLE_LIMIT     = 250000;
    localparam int MAX_PRINTED     = 100;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic                   peak_flag;
        logic                   turn_was_top;
        logic [SAMPLE_BITS-1:0] last_top;
        logic [SAMPLE_BITS-1:0] last_bottom;
    } peak_word_t;

    // Tracks the detector state for every accepted sample and holds the words still owed.
    class peak_scoreboard;
        logic [PERSIST_BITS-1:0] persist_count;
        logic [MARGIN_BITS-1:0]  margin;
        logic                    report_tops;
        logic                    report_bottoms;

        logic                    rising;
        sample_t                 extreme;
        logic [PERSIST_BITS-1:0] beyond_count;
        sample_t                 top_hold;
        sample_t                 bottom_hold;

        peak_word_t expected_words[$];
        int         errors;

        function new();
            persist_count  = 8'd1;
            margin         = '0;
            report_tops    = 1'b1;
            report_bottoms = 1'b0;
            rising         = 1'b1;
            extreme        = '0;
            beyond_count   = '0;
            top_hold       = '0;
            bottom_hold    = '0;
            errors         = 0;
        endfunction

        function void write_reg(cfg_addr_t index, logic [CFG_DATA_BITS-1:0] data);
            case (index)
                CFG_PERSIST_COUNT:  persist_count  = data[PERSIST_BITS-1:0];
                CFG_MARGIN:         margin         = data[MARGIN_BITS-1:0];
                CFG_REPORT_TOPS:    report_tops    = data[0];
                CFG_REPORT_BOTTOMS: report_bottoms = data[0];
                default: ;
            endcase
        endfunction

        function void predict_sample(sample_t s);
            logic signed [SAMPLE_BITS:0] wide_s;
            logic signed [SAMPLE_BITS:0] wide_x;
            logic signed [SAMPLE_BITS:0] wide_m;
            logic [PERSIST_BITS:0]       next_count;
            logic                        turn;
            peak_word_t                  word;

            wide_s     = s;
            wide_x     = extreme;
            wide_m     = $signed({2'b00, margin});
            next_count = {1'b0, beyond_count} + 1'b1;
            word       = '0;
            // The margin check is one bit wider so extreme +/- margin cannot overflow.
            turn = rising ? (wide_s < wide_x - wide_m) : (wide_s > wide_x + wide_m);
            if (turn) begin
                if (next_count >= {1'b0, persist_count}) begin
                    beyond_count = '0;
                    if (rising) begin
                        top_hold          = extreme;
                        word.turn_was_top = 1'b1;
                        word.peak_flag    = report_tops;
                    end else begin
                        bottom_hold    = extreme;
                        word.peak_flag = report_bottoms;
                    end
                    extreme = s;
                    rising  = !rising;
                end else begin
                    beyond_count = next_count[PERSIST_BITS-1:0];
                end
            end else if (rising ? (s > extreme) : (s < extreme)) begin
                beyond_count = '0;
                extreme      = s;
            end
            word.last_top    = top_hold;
            word.last_bottom = bottom_hold;
            expected_words.push_back(word);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task check_result(peak_word_t got);
            peak_word_t exp;
            if (expected_words.size() == 0) begin
                report("result word arrived with no sample outstanding");
            end else begin
                exp = expected_words.pop_front();
                if (got.peak_flag !== exp.peak_flag)
                    report($sformatf("peak_flag got %b expected %b",
                                     got.peak_flag, exp.peak_flag));
                if (got.turn_was_top !== exp.turn_was_top)
                    report($sformatf("turn_was_top got %b expected %b",
                                     got.turn_was_top, exp.turn_was_top));
                if (got.last_top !== exp.last_top)
                    report($sformatf("last_top got %0d expected %0d",
                                     $signed(got.last_top), $signed(exp.last_top)));
                if (got.last_bottom !== exp.last_bottom)
                    report($sformatf("last_bottom got %0d expected %0d",
                                     $signed(got.last_bottom), $signed(exp.last_bottom)));
            end
        endtask

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     cfg_we;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    sample_t                  s_sample;
    logic                     m_valid;
    logic                     m_ready;
    logic                     m_peak_flag;
    logic                     m_turn_was_top;
    sample_t                  m_last_top;
    sample_t                  m_last_bottom;

    peak_scoreboard peak_sb = new();
    peak_word_t     seen_word;
    int             burst_left  = 0;
    int             stall_mode  = 0;
    int             hold_seq    = 0;
    int             hold_seen   = 0;
    int             hold_left   = 0;
    int             pattern_pos = 0;
    int             cycle_count = 0;

    peak_valley_detector #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_peak_flag   (m_peak_flag),
        .m_turn_was_top(m_turn_was_top),
        .m_last_top    (m_last_top),
        .m_last_bottom (m_last_bottom)
    );

    always begin
        #(HALF_PERIOD) aclk = 1'b1;
        #(HALF_PERIOD) aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: check each accepted word, then pick the next ready level.
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            seen_word = '{m_peak_flag, m_turn_was_top, m_last_top, m_last_bottom};
            peak_sb.check_result(seen_word);
        end
        pattern_pos++;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            case (stall_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ((pattern_pos % 7) < 3);
            endcase
        end
    end

    task automatic send_sample(input sample_t value);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_valid  <= 1'b1;
        s_sample <= value;
        do @(posedge aclk); while (!s_ready);
        peak_sb.predict_sample(value);
        burst_left--;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (peak_sb.pending() != 0) @(posedge aclk);
    endtask

    // Writes all four registers on consecutive cycles; the model masks the words as the block does.
    task automatic apply_config(input logic [CFG_DATA_BITS-1:0] persist_word,
                                input logic [CFG_DATA_BITS-1:0] margin_word,
                                input logic [CFG_DATA_BITS-1:0] tops_word,
                                input logic [CFG_DATA_BITS-1:0] bottoms_word);
        cfg_addr_t                  idx [4];
        logic [CFG_DATA_BITS-1:0]   data [4];
        idx  = '{CFG_PERSIST_COUNT, CFG_MARGIN, CFG_REPORT_TOPS, CFG_REPORT_BOTTOMS};
        data = '{persist_word, margin_word, tops_word, bottoms_word};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_wdata <= data[i];
            @(posedge aclk);
            peak_sb.write_reg(idx[i], data[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // A sample placed against the current trend: on the band edge for beyond 0, past it otherwise.
    function automatic sample_t against_trend(int beyond);
        int target;
        if (peak_sb.rising)
            target = int'(peak_sb.extreme) - int'(peak_sb.margin) - beyond;
        else
            target = int'(peak_sb.extreme) + int'(peak_sb.margin) + beyond;
        if (target > 32767) target = 32767;
        if (target < -32768) target = -32768;
        return sample_t'(target);
    endfunction

    initial begin
        sample_t  rail_samples [8];
        int       persist_val;
        int       margin_val;
        int       tops_val;
        int       bottoms_val;
        int       walk_pos;
        int       trend;
        int       seg_left;
        int       step;
        sample_t  next_sample;

        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= CFG_PERSIST_COUNT;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_sample  <= '0;
        m_ready   <= 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: full-scale swings, repeats of the extreme, and small values near zero.
        rail_samples = '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
                         16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001};
        foreach (rail_samples[i]) send_sample(rail_samples[i]);

        // A persist count of zero (high bits set in the written word) acts like one.
        // Each pass probes equal-to-extreme, the band edge, and one step past it.
        wait_idle();
        apply_config(15'h7F00, 15'd256, 15'h7FFE, 15'h7FFF);
        repeat (2) begin
            send_sample(peak_sb.extreme);
            send_sample(against_trend(0));
            send_sample(against_trend(1));
        end

        // Build up a partial count, then lower the persist count while it is held.
        wait_idle();
        apply_config(15'd5, 15'd0, 15'd1, 15'd1);
        repeat (3) send_sample(against_trend(40));
        wait_idle();
        apply_config(15'd2, 15'd0, 15'd1, 15'd1);
        send_sample(against_trend(40));

        // Random part: a trending walk with random content plus some full-range noise.
        walk_pos = 0;
        trend    = 1;
        seg_left = 0;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin
                    persist_val = 1;   margin_val = 0;     tops_val = 1; bottoms_val = 0;
                end
                1: begin
                    persist_val = 255; margin_val = 32767; tops_val = 0; bottoms_val = 1;
                end
                default: begin
                    persist_val = $urandom_range(0, 8);
                    margin_val  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                              : $urandom_range(0, 2047);
                    tops_val    = $urandom_range(0, 1);
                    bottoms_val = $urandom_range(0, 1);
                end
            endcase
            wait_idle();
            apply_config(CFG_DATA_BITS'(($urandom() & 32'h7F00) | persist_val),
                         CFG_DATA_BITS'(margin_val),
                         CFG_DATA_BITS'(($urandom() & 32'h7FFE) | tops_val),
                         CFG_DATA_BITS'(($urandom() & 32'h7FFE) | bottoms_val));
            stall_mode <= ph % 3;
            // One long receiver hold-off so the pipeline fills and pushes back on the sender.
            if (ph == 2)
                hold_seq <= hold_seq + 1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (seg_left == 0) begin
                    trend    = -trend;
                    seg_left = $urandom_range(4, 40 + persist_val);
                end
                seg_left--;
                step     = $urandom_range(0, margin_val / 4 + 48);
                walk_pos = walk_pos + ((trend > 0) ? step : -step);
                if (walk_pos > 32767) walk_pos = 32767;
                if (walk_pos < -32768) walk_pos = -32768;
                if ($urandom_range(0, 9) == 0)
                    next_sample = sample_t'($urandom());
                else
                    next_sample = sample_t'(walk_pos);
                send_sample(next_sample);
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (peak_sb.errors == 0 && peak_sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
src/pvd_pkg.sv
src/pvd_cfg_regs.sv
src/pvd_track.sv
src/peak_valley_detector.sv
verif/tb_peak_valley_detector.sv
